// ===== sv/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the serial frame deframer: header bytes,
// command codes, register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0] HDR_BYTE0 = 8'h5A;
	localparam logic [7:0] HDR_BYTE1 = 8'hA5;
	localparam logic [7:0] CMD_ESC_TO_DASH = 8'h64;
	localparam logic [7:0] CMD_DASH_TO_ESC = 8'h65;
	localparam logic [7:0] HDR_FIELDS = 8'd3;	// dest, source, command

	typedef enum logic [1:0] {
		CK_INV_SUM16 = 2'd0,
		CK_SUM16     = 2'd1,
		CK_XOR8      = 2'd2,
		CK_ALT_INV   = 2'd3
	} ck_mode_t;

	typedef enum logic [1:0] {
		REG_CK_MODE  = 2'd0,
		REG_DASH     = 2'd1,
		REG_ESC      = 2'd2,
		REG_RESERVED = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		FT_OTHER     = 2'd0,
		FT_ESC2DASH  = 2'd1,
		FT_DASH2ESC  = 2'd2,
		FT_UNUSED    = 2'd3
	} frame_type_t;

	typedef enum logic [3:0] {
		ST_HUNT0,
		ST_HUNT1,
		ST_LEN,
		ST_BODY,
		ST_CKLO,
		ST_CKHI,
		ST_EVAL,
		ST_RD,
		ST_LD
	} sfd_state_t;

	typedef struct packed {
		logic cap_len;
		logic cap_body;
		logic cap_cklo;
		logic cap_ckhi;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic load_single;
		logic load_payload;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_hdr0;
		logic is_hdr1;
		logic is_zero;
		logic body_last;
		logic mismatch;
		logic cnt_zero;
		logic idx_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame controller: tracks the frame phase byte by byte, then sequences the
// check evaluation and the payload readout run.
// ----------------------------------------------------------------------------
module sfd_ctrl
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	sfd_state_t state_q, state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT0;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		case (state_q)
			ST_HUNT0: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept && sts.is_hdr0) state_d = ST_HUNT1;
			end
			ST_HUNT1: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept) begin
					if (sts.is_hdr1)      state_d = ST_LEN;
					else if (!sts.is_hdr0) state_d = ST_HUNT0;
				end
			end
			ST_LEN: begin
				in_ready    = 1'b1;
				accept      = in_valid;
				cmd.cap_len = accept;
				if (accept) state_d = sts.is_zero ? ST_CKLO : ST_BODY;
			end
			ST_BODY: begin
				in_ready     = 1'b1;
				accept       = in_valid;
				cmd.cap_body = accept;
				if (accept && sts.body_last) state_d = ST_CKLO;
			end
			ST_CKLO: begin
				in_ready     = 1'b1;
				accept       = in_valid;
				cmd.cap_cklo = accept;
				if (accept) state_d = ST_CKHI;
			end
			ST_CKHI: begin
				in_ready     = 1'b1;
				accept       = in_valid;
				cmd.cap_ckhi = accept;
				if (accept) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.mismatch || sts.cnt_zero) begin
					if (sts.out_free) begin
						cmd.load_single = 1'b1;
						state_d         = ST_HUNT0;
					end
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.load_payload = 1'b1;
					cmd.idx_inc      = 1'b1;
					state_d          = sts.idx_last ? ST_HUNT0 : ST_RD;
				end
			end
			default: begin
				state_d = ST_HUNT0;
			end
		endcase
	end

endmodule

// ===== sv/sfd_datapath.sv =====
// ----------------------------------------------------------------------------
// sfd_datapath
// Frame registers, running check, payload buffer, configuration registers
// and the result output register.
// ----------------------------------------------------------------------------
module sfd_datapath
	import sfd_pkg::*;
#(
	parameter int PAYLOAD_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [7:0]  data_byte,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [1:0]  frame_type,
	output logic [7:0]  length_byte,
	output logic [7:0]  dest,
	output logic [7:0]  source,
	output logic [7:0]  command,
	output logic [5:0]  payload_count,
	output logic [4:0]  payload_index,
	output logic [7:0]  payload_byte,
	output logic [15:0] checksum_rx,
	output logic        last
);

	localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int CW = $clog2(PAYLOAD_MAX + 1);

	// configuration
	logic [1:0]  ck_mode_q;
	logic [7:0]  dash_q, esc_q;

	// frame state
	logic [7:0]  len_q, pos_q;
	logic [15:0] sum_q;
	logic [7:0]  xor_q, dest_q, src_q, cmd_q, cklo_q, ckhi_q;
	logic [AW-1:0] idx_q;

	// payload buffer
	logic [7:0]  mem [PAYLOAD_MAX];
	logic [7:0]  rd_data_q;

	// output register
	logic        ov_q, st_q, last_q;
	logic [1:0]  ft_q;
	logic [7:0]  o_len_q, o_dest_q, o_src_q, o_cmd_q, o_pb_q;
	logic [5:0]  o_cnt_q;
	logic [4:0]  o_idx_q;
	logic [15:0] o_rx_q;

	logic [8:0]  pos_next;
	logic [7:0]  pay_off;
	logic        mem_we;
	logic [7:0]  diff;
	logic [CW-1:0] cnt;
	logic [15:0] rx, expected;
	logic [1:0]  ftype;

	assign pos_next = {1'b0, pos_q} + 9'd1;
	assign pay_off  = pos_q - HDR_FIELDS;
	assign mem_we   = cmd.cap_body && (pos_q >= HDR_FIELDS)
		&& (pay_off < 8'(PAYLOAD_MAX));
	assign rx       = {ckhi_q, cklo_q};

	always_comb begin
		case (ck_mode_t'(ck_mode_q))
			CK_SUM16: expected = sum_q;
			CK_XOR8:  expected = {8'h00, xor_q};
			default:  expected = ~sum_q;
		endcase
	end

	always_comb begin
		diff = (len_q >= HDR_FIELDS) ? (len_q - HDR_FIELDS) : 8'd0;
		cnt  = (diff > 8'(PAYLOAD_MAX)) ? CW'(PAYLOAD_MAX) : CW'(diff);
	end

	always_comb begin
		if (cmd_q == CMD_ESC_TO_DASH && dest_q == dash_q && src_q == esc_q)
			ftype = FT_ESC2DASH;
		else if (cmd_q == CMD_DASH_TO_ESC && dest_q == esc_q && src_q == dash_q)
			ftype = FT_DASH2ESC;
		else
			ftype = FT_OTHER;
	end

	always_comb begin
		sts.is_hdr0   = (data_byte == HDR_BYTE0);
		sts.is_hdr1   = (data_byte == HDR_BYTE1);
		sts.is_zero   = (data_byte == 8'd0);
		sts.body_last = (pos_next >= {1'b0, len_q});
		sts.mismatch  = (rx != expected);
		sts.cnt_zero  = (cnt == '0);
		sts.idx_last  = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(cnt);
		sts.out_free  = !ov_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_mode_q <= CK_INV_SUM16;
			dash_q    <= '0;
			esc_q     <= '0;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_CK_MODE: ck_mode_q <= cfg_data[1:0];
				REG_DASH:    dash_q    <= cfg_data;
				REG_ESC:     esc_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pos_q  <= '0;
			sum_q  <= '0;
			xor_q  <= '0;
			dest_q <= '0;
			src_q  <= '0;
			cmd_q  <= '0;
			cklo_q <= '0;
			ckhi_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.cap_len) begin
				len_q  <= data_byte;
				pos_q  <= '0;
				sum_q  <= {8'h00, data_byte};
				xor_q  <= data_byte;
				dest_q <= '0;
				src_q  <= '0;
				cmd_q  <= '0;
			end
			if (cmd.cap_body) begin
				if (pos_q == 8'd0) dest_q <= data_byte;
				if (pos_q == 8'd1) src_q  <= data_byte;
				if (pos_q == 8'd2) cmd_q  <= data_byte;
				sum_q <= sum_q + {8'h00, data_byte};
				xor_q <= xor_q ^ data_byte;
				pos_q <= pos_next[7:0];
			end
			if (cmd.cap_cklo) cklo_q <= data_byte;
			if (cmd.cap_ckhi) ckhi_q <= data_byte;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[pay_off[AW-1:0]] <= data_byte;
		if (cmd.rd_en) rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_payload) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single || cmd.load_payload) begin
			o_len_q  <= len_q;
			o_dest_q <= dest_q;
			o_src_q  <= src_q;
			o_cmd_q  <= cmd_q;
			o_rx_q   <= rx;
		end
		if (cmd.load_single) begin
			st_q    <= sts.mismatch;
			ft_q    <= sts.mismatch ? FT_OTHER : ftype;
			o_cnt_q <= '0;
			o_idx_q <= '0;
			o_pb_q  <= '0;
			last_q  <= 1'b1;
		end else if (cmd.load_payload) begin
			st_q    <= 1'b0;
			ft_q    <= ftype;
			o_cnt_q <= 6'(cnt);
			o_idx_q <= 5'(idx_q);
			o_pb_q  <= rd_data_q;
			last_q  <= sts.idx_last;
		end
	end

	assign out_valid     = ov_q;
	assign status        = st_q;
	assign frame_type    = ft_q;
	assign length_byte   = o_len_q;
	assign dest          = o_dest_q;
	assign source        = o_src_q;
	assign command       = o_cmd_q;
	assign payload_count = o_cnt_q;
	assign payload_index = o_idx_q;
	assign payload_byte  = o_pb_q;
	assign checksum_rx   = o_rx_q;
	assign last          = last_q;

endmodule

// ===== sv/serial_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Byte-stream frame parser with selectable check word and payload readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/data_byte) carries one received serial
//   byte per transaction. While a frame is being hunted or received, a byte
//   is taken every cycle.
//   When the check word high byte is taken, the block evaluates the check
//   and, for a good frame with stored payload, reads the payload buffer
//   back out: one result per stored byte, each taking a buffer read state
//   and then a load state, paced by the single read port of the buffer. A
//   bad check, or a good frame with no stored payload, yields one result.
//   The input stays stalled from the check word until the last result is
//   loaded into the output register.
//   Output channel (out_valid/out_ready) is a single output register; if the
//   receiver stalls, the run waits and the register holds its result.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once
//   and should be made while no frame is in flight.
//   Reset clears the frame state, the registers and the output valid; the
//   payload buffer is not cleared (entries are always written before read).
// ----------------------------------------------------------------------------
module serial_frame_deframer
	import sfd_pkg::*;
#(
	parameter int PAYLOAD_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [1:0]  frame_type,
	output logic [7:0]  length_byte,
	output logic [7:0]  dest,
	output logic [7:0]  source,
	output logic [7:0]  command,
	output logic [5:0]  payload_count,
	output logic [4:0]  payload_index,
	output logic [7:0]  payload_byte,
	output logic [15:0] checksum_rx,
	output logic        last
);

	ctrl_cmd_t  cmd;	// controller -> datapath
	dp_status_t sts;	// datapath -> controller

	// Phase tracking and readout sequencing
	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Frame registers, check, payload buffer, output register
	sfd_datapath #(
		.PAYLOAD_MAX (PAYLOAD_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.frame_type    (frame_type),
		.length_byte   (length_byte),
		.dest          (dest),
		.source        (source),
		.command       (command),
		.payload_count (payload_count),
		.payload_index (payload_index),
		.payload_byte  (payload_byte),
		.checksum_rx   (checksum_rx),
		.last          (last)
	);

endmodule

// ===== sv/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module sfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic [1:0]  frame_type,
	input logic [7:0]  length_byte,
	input logic [7:0]  dest,
	input logic [7:0]  source,
	input logic [7:0]  command,
	input logic [5:0]  payload_count,
	input logic [4:0]  payload_index,
	input logic [7:0]  payload_byte,
	input logic [15:0] checksum_rx,
	input logic        last
);

	// stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result keeps every field
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({status, frame_type, length_byte, dest,
			source, command, payload_count, payload_index, payload_byte,
			checksum_rx, last}))
		else $error("stalled result changed");

	// a check error is a lone, untyped result with no payload
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last && frame_type == 2'd0 && payload_count == 6'd0)
		else $error("malformed error result");

	// only a good frame with stored payload can have a non-final result
	a_run_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !status && payload_count != 6'd0)
		else $error("non-final result outside a payload run");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (.*);
